FILE: hdl/bia_pkg.sv
// Package for the bitmap id allocator: widths, FNV-1a constants, request codes,
// the queued item type, the back-end state encoding and small helper functions.
// No dependencies.
package bia_pkg;

  // Map geometry: 1024 ids held as 32 words of 32 bits
  localparam int MAX_IDS    = 1024;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int MAP_IDX_W  = $clog2(MAP_WORDS);
  localparam int ID_W       = 10;

  // Hash: 32-bit FNV-1a; the bin count is a power of two, so the modulo is a mask
  localparam int HASH_W     = 32;
  localparam int NUM_BINS   = 128;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'h01000193;

  // Request codes
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Classified request handed from front end to back end
  typedef struct packed {
    logic            rel;
    logic [ID_W-1:0] id;
  } item_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_REL_WR,
    B_HASH1,
    B_HASH2,
    B_RESP
  } back_state_t;

  // Word value of a map entry that was never written since reset
  function automatic logic [WORD_BITS-1:0] reset_word(input logic [MAP_IDX_W-1:0] addr);
    logic [WORD_BITS-1:0] w;
    w = '0;
    if (addr == '0) begin
      w[0] = 1'b1;
    end
    return w;
  endfunction

  // Index of the lowest clear bit of a word (word assumed not all ones)
  function automatic logic [BIT_IDX_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: hdl/bia_front.sv
// Front end of the id allocator: takes request transfers, classifies them as
// allocate or release and holds them in a two-entry queue for the back end.
// Depends on bia_pkg.
module bia_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [bia_pkg::ID_W-1:0]   release_id,
  output logic                       item_valid,
  input  logic                       item_ready,
  output bia_pkg::item_t             item
);

  localparam int DEPTH = 2;

  bia_pkg::item_t q [DEPTH];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;
  bia_pkg::item_t in_item;

  // Classify the incoming request
  always_comb begin
    in_item.rel = (req_type == bia_pkg::REQ_RELEASE);
    in_item.id  = release_id;
  end

  assign in_ready   = (count != 2'(DEPTH));
  assign push       = in_valid && in_ready;
  assign item_valid = (count != 2'd0);
  assign pop        = item_valid && item_ready;
  assign item       = q[rptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= in_item;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Fill count stays within the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH))
    else $error("queue count above depth");

  // A push into a full queue would drop a request
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'(DEPTH) |-> !push)
    else $error("push into full queue");

  // Count rises by one after a push without a pop
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("count did not follow push");

endmodule

FILE: hdl/bia_back.sv
// Back end of the id allocator: id bitmap memory, word scan for the lowest free
// id, release read-modify-write, two-step FNV-1a hash and the result register.
// Depends on bia_pkg.
module bia_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  bia_pkg::item_t              item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        ok,
  output logic [bia_pkg::ID_W-1:0]    given_id,
  output logic [bia_pkg::BIN_W-1:0]   bucket
);

  bia_pkg::back_state_t state;
  bia_pkg::back_state_t state_next;

  // Bitmap memory with per-word written flags
  logic [bia_pkg::WORD_BITS-1:0] mem [bia_pkg::MAP_WORDS];
  logic [bia_pkg::MAP_WORDS-1:0] vld;
  logic                          rd_en;
  logic [bia_pkg::MAP_IDX_W-1:0] rd_addr;
  logic [bia_pkg::WORD_BITS-1:0] rd_word;
  logic                          rd_vld;
  logic [bia_pkg::MAP_IDX_W-1:0] rd_addr_q;
  logic                          wr_en;
  logic [bia_pkg::WORD_BITS-1:0] wr_data;

  // Scan control
  logic [bia_pkg::MAP_IDX_W:0]   scan_addr;
  logic                          chk_valid;

  // Per-request working registers
  logic [bia_pkg::ID_W-1:0]      cur_id;
  logic [bia_pkg::HASH_W-1:0]    h0;
  logic [bia_pkg::HASH_W-1:0]    h0_next;
  logic [bia_pkg::HASH_W-1:0]    h1;
  logic                          res_ok;
  logic [bia_pkg::ID_W-1:0]      res_id;
  logic [bia_pkg::BIN_W-1:0]     res_bucket;
  logic                          load_out;

  // Decoded read word
  logic [bia_pkg::WORD_BITS-1:0] word_eff;
  logic                          word_free;
  logic [bia_pkg::BIT_IDX_W-1:0] free_bit;
  logic [bia_pkg::ID_W-1:0]      found_id;
  logic                          found;
  logic                          scan_fail;

  assign word_eff  = rd_vld ? rd_word : bia_pkg::reset_word(rd_addr_q);
  assign word_free = (~word_eff != '0);
  assign free_bit  = bia_pkg::lowest_zero(word_eff);
  assign found_id  = {rd_addr_q, free_bit};
  assign found     = (state == bia_pkg::B_SCAN) && chk_valid && word_free;
  assign scan_fail = (state == bia_pkg::B_SCAN) && chk_valid && !word_free &&
                     (rd_addr_q == bia_pkg::MAP_IDX_W'(bia_pkg::MAP_WORDS - 1));

  // FNV-1a rounds: low byte, then high byte
  assign h0_next = (bia_pkg::FNV_BASIS ^ {{(bia_pkg::HASH_W-8){1'b0}}, cur_id[7:0]})
                   * bia_pkg::FNV_PRIME;
  assign h1      = (h0 ^ {{(bia_pkg::HASH_W-bia_pkg::ID_W+8){1'b0}},
                          cur_id[bia_pkg::ID_W-1:8]}) * bia_pkg::FNV_PRIME;

  // Next state, memory port control, handshakes
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = scan_addr[bia_pkg::MAP_IDX_W-1:0];
    wr_en      = 1'b0;
    wr_data    = word_eff;
    item_ready = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      bia_pkg::B_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item.rel) begin
            // read the target word now, write it back next cycle
            rd_en      = 1'b1;
            rd_addr    = item.id[bia_pkg::ID_W-1:bia_pkg::BIT_IDX_W];
            state_next = bia_pkg::B_REL_WR;
          end else begin
            state_next = bia_pkg::B_SCAN;
          end
        end
      end
      bia_pkg::B_SCAN: begin
        // one word read per cycle, each checked in the cycle after its read
        rd_en = !scan_addr[bia_pkg::MAP_IDX_W];
        if (found) begin
          wr_en      = 1'b1;
          wr_data    = word_eff | (bia_pkg::WORD_BITS'(1) << free_bit);
          state_next = bia_pkg::B_HASH1;
        end else if (scan_fail) begin
          state_next = bia_pkg::B_RESP;
        end
      end
      bia_pkg::B_REL_WR: begin
        wr_en      = 1'b1;
        wr_data    = word_eff &
                     ~(bia_pkg::WORD_BITS'(1) << cur_id[bia_pkg::BIT_IDX_W-1:0]);
        state_next = bia_pkg::B_RESP;
      end
      bia_pkg::B_HASH1: begin
        state_next = bia_pkg::B_HASH2;
      end
      bia_pkg::B_HASH2: begin
        state_next = bia_pkg::B_RESP;
      end
      bia_pkg::B_RESP: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = bia_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = bia_pkg::B_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bia_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Bitmap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_addr_q] <= wr_data;
    end
    if (rd_en) begin
      rd_word   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Written flags: an unwritten word reads as its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[rd_addr_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // Scan counter and check flag
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= (state == bia_pkg::B_SCAN) && rd_en;
      if (state == bia_pkg::B_IDLE) begin
        scan_addr <= '0;
      end else if ((state == bia_pkg::B_SCAN) && rd_en) begin
        scan_addr <= scan_addr + 1'b1;
      end
    end
  end

  // Working registers and pending result
  always_ff @(posedge clk) begin
    if ((state == bia_pkg::B_IDLE) && item_valid) begin
      cur_id     <= item.id;
      res_ok     <= 1'b1;
      res_id     <= '0;
      res_bucket <= '0;
    end
    if (found) begin
      cur_id <= found_id;
      res_id <= found_id;
    end
    if (scan_fail) begin
      res_ok <= 1'b0;
    end
    if (state == bia_pkg::B_HASH1) begin
      h0 <= h0_next;
    end
    if (state == bia_pkg::B_HASH2) begin
      res_bucket <= h1[bia_pkg::BIN_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ok       <= res_ok;
      given_id <= res_id;
      bucket   <= res_bucket;
    end
  end

  // A failed allocate carries a zero id and bucket
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> given_id == '0 && bucket == '0)
    else $error("failed allocate with nonzero payload");

  // An allocate marks exactly one more id in the word
  a_alloc_one_bit: assert property (@(posedge clk) disable iff (rst)
    found |-> $countones(wr_data) == $countones(word_eff) + 1)
    else $error("allocate did not set exactly one bit");

  // The scan never runs past the last word without a check pending
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == bia_pkg::B_SCAN && scan_addr[bia_pkg::MAP_IDX_W] |-> chk_valid)
    else $error("scan ran past last map word");

  // Release write-back follows the read issued at pop
  a_rel_order: assert property (@(posedge clk) disable iff (rst)
    state == bia_pkg::B_REL_WR |-> $past(state) == bia_pkg::B_IDLE)
    else $error("release write without preceding read");

endmodule

FILE: hdl/bitmap_id_allocator_with_hash_bucket.sv
// Identifier allocator with FNV-1a hash bucket, top level.
// Usage:
//   Request channel (in_valid/in_ready): req_type 0 allocates the lowest free
//   id, req_type 1 releases release_id (no check; id 0 may be released too).
//   Result channel (out_valid/out_ready): one transfer per request carrying
//   ok, given_id and bucket. A failed allocate gives ok 0, id 0, bucket 0;
//   a release gives ok 1, id 0, bucket 0.
// Timing:
//   A two-entry request queue sits in front of the back end. Once a request
//   leaves the queue, a release reads and writes back its map word, and an
//   allocate scans the map words in order up to the first with a free bit,
//   then hashes the id in two steps. The bitmap is a 32 x 32 memory
//   read one word per cycle, and the scan over it sets the allocate time.
//   One request is worked on at a time.
// Reset: rst is synchronous; afterwards only id 0 is marked used and the
//   queue and result register are empty. No clearing pass is needed.
// Stalls: a held result keeps the back end waiting in its result state while
//   the queue still takes new requests until it is full.
// Depends on bia_pkg, bia_front and bia_back.
module bitmap_id_allocator_with_hash_bucket (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [bia_pkg::ID_W-1:0]    release_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        ok,
  output logic [bia_pkg::ID_W-1:0]    given_id,
  output logic [bia_pkg::BIN_W-1:0]   bucket
);

  logic           item_valid;
  logic           item_ready;
  bia_pkg::item_t item;

  // Request intake and queue
  bia_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .release_id (release_id),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // Bitmap, scan, hash and result
  bia_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .given_id   (given_id),
    .bucket     (bucket)
  );

endmodule

FILE: tb/bitmap_id_allocator_with_hash_bucket_tb.sv
// Self-checking testbench for the bitmap id allocator with FNV-1a hash bucket.
// Drives directed and random allocate/release transfers with random idling on both sides,
// predicts each result from its own id map, and checks every result. Uses bia_pkg and the top level.
module bitmap_id_allocator_with_hash_bucket_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 64;

  // One predicted result of the allocator
  typedef struct {
    bit                      ok;
    bit [bia_pkg::ID_W-1:0]  id;
    bit [bia_pkg::BIN_W-1:0] bin;
  } grant_t;

  // Tracks which ids are taken and the results still owed by the block
  class id_ledger;
    bit     taken[bia_pkg::MAX_IDS];
    grant_t grants_due[$];
    int     mismatches;

    function new();
      foreach (taken[i]) taken[i] = 1'b0;
      taken[0] = 1'b1;  // id 0 reserved at reset
      mismatches = 0;
    endfunction

    // FNV-1a over the id's low byte then high byte, reduced to a bin
    function bit [bia_pkg::BIN_W-1:0] bin_of(bit [bia_pkg::ID_W-1:0] id);
      bit [bia_pkg::HASH_W-1:0] h;
      h = bia_pkg::FNV_BASIS;
      h ^= bia_pkg::HASH_W'(id[7:0]);
      h = h * bia_pkg::FNV_PRIME;
      h ^= bia_pkg::HASH_W'(id >> 8);
      h = h * bia_pkg::FNV_PRIME;
      return h[bia_pkg::BIN_W-1:0];
    endfunction

    function int free_count();
      int n;
      n = 0;
      foreach (taken[i]) if (!taken[i]) n++;
      return n;
    endfunction

    function int pending();
      return grants_due.size();
    endfunction

    // Random id that is currently taken, or any id if none turns up quickly
    function bit [bia_pkg::ID_W-1:0] pick_taken();
      bit [bia_pkg::ID_W-1:0] id;
      id = '0;
      for (int t = 0; t < 64; t++) begin
        id = bia_pkg::ID_W'($urandom_range(0, bia_pkg::MAX_IDS - 1));
        if (taken[id]) return id;
      end
      return id;
    endfunction

    // Accepted request: update the map and queue the result it will produce
    function void note_request(logic kind, logic [bia_pkg::ID_W-1:0] rid);
      grant_t g;
      g.ok = 1'b1;
      g.id = '0;
      g.bin = '0;
      if (kind == bia_pkg::REQ_RELEASE) begin
        taken[rid] = 1'b0;
      end else begin
        g.ok = 1'b0;
        for (int i = 0; i < bia_pkg::MAX_IDS; i++) begin
          if (!taken[i]) begin
            taken[i] = 1'b1;
            g.ok = 1'b1;
            g.id = bia_pkg::ID_W'(i);
            g.bin = bin_of(bia_pkg::ID_W'(i));
            break;
          end
        end
      end
      grants_due.push_back(g);
    endfunction

    // Accepted result: compare with the oldest outstanding prediction
    function void check_grant(logic r_ok, logic [bia_pkg::ID_W-1:0] r_id,
                              logic [bia_pkg::BIN_W-1:0] r_bin);
      grant_t g;
      if (grants_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with nothing outstanding: ok=%0b id=%0d bucket=%0d",
                   r_ok, r_id, r_bin);
        return;
      end
      g = grants_due.pop_front();
      if (r_ok !== g.ok || r_id !== g.id || r_bin !== g.bin) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected ok=%0b id=%0d bucket=%0d, got ok=%0b id=%0d bucket=%0d",
                   g.ok, g.id, g.bin, r_ok, r_id, r_bin);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       req_type = bia_pkg::REQ_ALLOC;
  logic [bia_pkg::ID_W-1:0]   release_id = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       ok;
  logic [bia_pkg::ID_W-1:0]   given_id;
  logic [bia_pkg::BIN_W-1:0]  bucket;

  id_ledger ledger = new();
  bit       send_steady = 1'b0;
  bit       take_steady = 1'b0;
  int       cycles = 0;

  bitmap_id_allocator_with_hash_bucket u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .release_id (release_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .given_id   (given_id),
    .bucket     (bucket)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // One request transfer; valid stays up across back-to-back transfers
  task automatic send_req(input logic kind, input logic [bia_pkg::ID_W-1:0] rid);
    int gap;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    release_id <= rid;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(kind, rid);
  endtask

  task automatic wait_drained();
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // Random allocate or release, releases aimed mostly at taken ids
  task automatic send_mixed(input int alloc_pct);
    if ($urandom_range(0, 99) < alloc_pct)
      send_req(bia_pkg::REQ_ALLOC, bia_pkg::ID_W'($urandom));
    else if ($urandom_range(0, 99) < 60)
      send_req(bia_pkg::REQ_RELEASE, ledger.pick_taken());
    else
      send_req(bia_pkg::REQ_RELEASE,
               bia_pkg::ID_W'($urandom_range(0, bia_pkg::MAX_IDS - 1)));
  endtask

  // Result side: random stall before each result, then check it
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
      stall = take_steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      ledger.check_grant(ok, given_id, bucket);
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("bitmap_id_allocator_with_hash_bucket_tb: FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    int guard;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: first grants, reuse of a freed id, reserved id 0, free-id releases
    send_req(bia_pkg::REQ_ALLOC, '0);
    send_req(bia_pkg::REQ_ALLOC, '1);
    send_req(bia_pkg::REQ_ALLOC, 10'h155);
    send_req(bia_pkg::REQ_RELEASE, 10'd2);
    send_req(bia_pkg::REQ_ALLOC, 10'h2AA);
    send_req(bia_pkg::REQ_RELEASE, 10'd0);
    send_req(bia_pkg::REQ_ALLOC, '0);
    send_req(bia_pkg::REQ_RELEASE, 10'd1023);
    send_req(bia_pkg::REQ_RELEASE, 10'h2AA);
    send_req(bia_pkg::REQ_RELEASE, 10'h155);
    send_req(bia_pkg::REQ_ALLOC, '0);
    send_req(bia_pkg::REQ_RELEASE, 10'd1);
    send_req(bia_pkg::REQ_RELEASE, 10'd3);
    send_req(bia_pkg::REQ_RELEASE, 10'd3);
    send_req(bia_pkg::REQ_ALLOC, '0);
    send_req(bia_pkg::REQ_ALLOC, '0);

    // Churn with a sparse map
    repeat (550) send_mixed(55);

    // Hold off the sender until the block has answered everything
    in_valid <= 1'b0;
    wait_drained();

    // Fill the map, with the odd release, then run into exhaustion
    guard = 0;
    while (ledger.free_count() > 0 && guard < 2 * bia_pkg::MAX_IDS) begin
      if ($urandom_range(0, 99) < 5)
        send_req(bia_pkg::REQ_RELEASE, ledger.pick_taken());
      else
        send_req(bia_pkg::REQ_ALLOC, bia_pkg::ID_W'($urandom));
      guard++;
    end
    repeat (8) send_req(bia_pkg::REQ_ALLOC, bia_pkg::ID_W'($urandom));

    // Top id and reserved id freed on a full map and granted again
    send_req(bia_pkg::REQ_RELEASE, 10'd1023);
    send_req(bia_pkg::REQ_ALLOC, '0);
    send_req(bia_pkg::REQ_RELEASE, 10'd0);
    send_req(bia_pkg::REQ_ALLOC, '0);
    send_req(bia_pkg::REQ_ALLOC, '0);

    // Churn near full, failures mixed in
    repeat (200) send_mixed(50);

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0)
      $display("bitmap_id_allocator_with_hash_bucket_tb: PASS");
    else
      $display("bitmap_id_allocator_with_hash_bucket_tb: FAIL");
    $finish;
  end

endmodule
